[rtl/core/pbfc_pkg.sv]
// ----------------------------------------------------------------------------
// pbfc_pkg: shared definitions for the playback position and fade controller
// Widths, fixed-point constants, command codes and the control and status
// structs that link the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package pbfc_pkg;

  // Position is signed, -1 means not started.
  localparam int TIME_WIDTH     = 25;
  // Fade level is Q1.FADE_FRAC_BITS.
  localparam int FADE_FRAC_BITS = 15;

  localparam int DUR_W     = 24;
  localparam int MS_W      = 16;
  localparam int LEN_W     = 16;
  localparam int CMD_W     = 3;
  localparam int MODE_W    = 2;
  localparam int LVL_W     = FADE_FRAC_BITS + 1;
  localparam int POS_MAG_W = TIME_WIDTH - 1;

  // Ramp numerator: elapsed times distance plus the carried remainder.
  localparam int NUM_W     = MS_W + LVL_W;
  localparam int DVD_W     = (NUM_W > POS_MAG_W) ? NUM_W : POS_MAG_W;
  localparam int DVS_W     = (DUR_W > LEN_W) ? DUR_W : LEN_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int CFG_W     = DUR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [LVL_W-1:0]      FADE_ONE = LVL_W'(1) << FADE_FRAC_BITS;
  localparam logic [TIME_WIDTH-1:0] POS_MAX  = {1'b0, {POS_MAG_W{1'b1}}};
  localparam logic [TIME_WIDTH-1:0] POS_NONE = {TIME_WIDTH{1'b1}};

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION = 1'b0,
    CFG_LOOP     = 1'b1
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_PLAY    = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_PAUSE   = 3'd3,
    CMD_FADE    = 3'd4,
    CMD_ADVANCE = 3'd5
  } cmd_code_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2
  } fade_mode_e;

  // Datapath operations, each one performed at the clock edge ending the
  // cycle in which it is presented.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXEC,
    OP_MOD_START,
    OP_TICK_POS,
    OP_MUL,
    OP_RAMP_START,
    OP_FADE
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } pbfc_ctl_t;

  typedef struct packed {
    logic is_tick;
    logic active;
    logic paused;
    logic wrap_loop;
    logic fade_run;
    logic span_zero;
    logic div_done;
  } pbfc_stat_t;

  typedef struct packed {
    logic signed [TIME_WIDTH-1:0] position_ms;
    logic [LVL_W-1:0]             fade_level;
    logic                         is_active;
    logic [MODE_W-1:0]            fade_mode_now;
    logic                         is_paused;
  } pbfc_res_t;

endpackage

[rtl/core/pbfc_if.sv]
// ----------------------------------------------------------------------------
// pbfc_if: valid/ready channels of the playback controller
// pbfc_cmd_if carries command beats in, pbfc_res_if carries result beats out.
// ----------------------------------------------------------------------------
interface pbfc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [pbfc_pkg::CMD_W-1:0]     cmd;
  logic [pbfc_pkg::MS_W-1:0]      elapsed_ms;
  logic [pbfc_pkg::MODE_W-1:0]    fade_request;
  logic [pbfc_pkg::LEN_W-1:0]     fade_length_ms;
  logic                           pause_flag;

  modport source (
    output valid, cmd, elapsed_ms, fade_request, fade_length_ms, pause_flag,
    input  ready
  );
  modport sink (
    input  valid, cmd, elapsed_ms, fade_request, fade_length_ms, pause_flag,
    output ready
  );
endinterface

interface pbfc_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pbfc_pkg::TIME_WIDTH-1:0] position_ms;
  logic [pbfc_pkg::LVL_W-1:0]            fade_level;
  logic                                  is_active;
  logic [pbfc_pkg::MODE_W-1:0]           fade_mode_now;
  logic                                  is_paused;

  modport source (
    output valid, position_ms, fade_level, is_active, fade_mode_now, is_paused,
    input  ready
  );
  modport sink (
    input  valid, position_ms, fade_level, is_active, fade_mode_now, is_paused,
    output ready
  );
endinterface

[rtl/core/pbfc_div.sv]
// ----------------------------------------------------------------------------
// pbfc_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when quotient and
// remainder are valid. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pbfc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pbfc_pkg::DVD_W-1:0] dividend_i,
  input  logic [pbfc_pkg::DVS_W-1:0] divisor_i,
  output logic [pbfc_pkg::DVD_W-1:0] quot_o,
  output logic [pbfc_pkg::DVS_W-1:0] rem_o,
  output logic                       done_o
);
  import pbfc_pkg::*;

  logic [DVD_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 geq;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign geq   = (trial >= {1'b0, dvs_q});
  assign rem_d = geq ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the dividend register as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], geq};
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

[rtl/core/pbfc_datapath.sv]
// ----------------------------------------------------------------------------
// pbfc_datapath: playback state, configuration and arithmetic
// Holds position, fade and flag state, latches command beats, and carries
// out the operations issued by the controller, with a shared divider for
// the loop wrap and the fade ramp.
// ----------------------------------------------------------------------------
module pbfc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbfc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [pbfc_pkg::CMD_W-1:0]     cmd_i,
  input  logic [pbfc_pkg::MS_W-1:0]      elapsed_ms_i,
  input  logic [pbfc_pkg::MODE_W-1:0]    fade_request_i,
  input  logic [pbfc_pkg::LEN_W-1:0]     fade_length_ms_i,
  input  logic                           pause_flag_i,
  input  pbfc_pkg::pbfc_ctl_t            ctl_i,
  output pbfc_pkg::pbfc_stat_t           stat_o,
  output pbfc_pkg::pbfc_res_t            res_o
);
  import pbfc_pkg::*;

  localparam int CMP_W = (POS_MAG_W > DUR_W) ? POS_MAG_W : DUR_W;

  function automatic logic [TIME_WIDTH-1:0] sat_add(
    input logic [TIME_WIDTH-1:0] base,
    input logic [MS_W-1:0]       ms
  );
    logic [TIME_WIDTH-1:0] sum;
    sum = base + TIME_WIDTH'(ms);
    return (sum > POS_MAX) ? POS_MAX : sum;
  endfunction

  // Configuration.
  logic [DUR_W-1:0] dur_q;
  logic             loop_q;

  // Playback and fade state.
  logic signed [TIME_WIDTH-1:0] pos_q;
  logic [LVL_W-1:0]             weight_q;
  logic [LVL_W-1:0]             start_q;
  fade_mode_e                   mode_q;
  logic [LEN_W-1:0]             span_q;
  logic [LEN_W-1:0]             frem_q;
  logic                         active_q;
  logic                         pause_q;

  // Latched command beat and the ramp product.
  logic [CMD_W-1:0]  cmd_q;
  logic [MS_W-1:0]   ms_q;
  logic [MODE_W-1:0] req_q;
  logic [LEN_W-1:0]  len_q;
  logic              pz_q;
  logic [NUM_W-1:0]  prod_q;

  // Divider connection.
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;
  logic             div_done;

  logic [DUR_W-1:0]      dur_eff;
  logic                  pos_neg;
  logic                  wrap;
  logic [TIME_WIDTH-1:0] pos_base;
  logic [LVL_W-1:0]      ramp_dist;
  fade_mode_e            req_mode;
  fade_mode_e            play_mode;
  logic [DVD_W:0]        lvl_sum;

  assign dur_eff  = (dur_q == '0) ? DUR_W'(1) : dur_q;
  assign pos_neg  = pos_q[TIME_WIDTH-1];
  assign wrap     = !pos_neg &&
                    (CMP_W'(pos_q[POS_MAG_W-1:0]) >= CMP_W'(dur_eff));
  assign pos_base = (wrap && loop_q) ? TIME_WIDTH'(div_rem) : pos_q;

  always_comb begin
    if (mode_q == MODE_IN) begin
      ramp_dist = (start_q < FADE_ONE) ? (FADE_ONE - start_q) : '0;
    end else begin
      ramp_dist = start_q;
    end
  end

  // Request code three is handled as no fade.
  always_comb begin
    unique case (req_q)
      MODE_IN:  req_mode = MODE_IN;
      MODE_OUT: req_mode = MODE_OUT;
      default:  req_mode = MODE_NONE;
    endcase
  end

  assign play_mode = (mode_q == MODE_OUT) ? MODE_NONE : mode_q;
  assign lvl_sum   = {1'b0, div_quot} + (DVD_W + 1)'(weight_q);

  assign div_start = (ctl_i.op == OP_MOD_START) || (ctl_i.op == OP_RAMP_START);
  always_comb begin
    if (ctl_i.op == OP_MOD_START) begin
      div_dividend = DVD_W'(pos_q[POS_MAG_W-1:0]);
      div_divisor  = DVS_W'(dur_eff);
    end else begin
      div_dividend = DVD_W'(prod_q + NUM_W'(frem_q));
      div_divisor  = DVS_W'(span_q);
    end
  end

  pbfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      ms_q  <= elapsed_ms_i;
      req_q <= fade_request_i;
      len_q <= fade_length_ms_i;
      pz_q  <= pause_flag_i;
    end
    if (ctl_i.op == OP_MUL) begin
      prod_q <= NUM_W'(ms_q) * NUM_W'(ramp_dist);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q    <= DUR_RESET;
      loop_q   <= 1'b0;
      pos_q    <= POS_NONE;
      weight_q <= FADE_ONE;
      start_q  <= FADE_ONE;
      mode_q   <= MODE_NONE;
      span_q   <= '0;
      frem_q   <= '0;
      active_q <= 1'b0;
      pause_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_DURATION: dur_q  <= cfg_data_i[DUR_W-1:0];
          CFG_LOOP:     loop_q <= cfg_data_i[0];
        endcase
      end

      unique case (ctl_i.op)
        OP_EXEC: begin
          unique case (cmd_q)
            CMD_PLAY: begin
              if (!active_q) begin
                pos_q    <= POS_NONE;
                mode_q   <= play_mode;
                active_q <= (play_mode == MODE_IN) || (weight_q != '0);
              end
              pause_q <= 1'b0;
            end
            CMD_STOP: begin
              mode_q   <= MODE_NONE;
              pos_q    <= POS_NONE;
              active_q <= 1'b0;
            end
            CMD_PAUSE: begin
              pause_q <= pz_q;
            end
            CMD_FADE: begin
              if (req_mode == MODE_NONE) begin
                weight_q <= FADE_ONE;
                start_q  <= FADE_ONE;
              end else if (mode_q != MODE_OUT && req_mode == MODE_IN) begin
                weight_q <= '0;
                start_q  <= '0;
              end else begin
                start_q <= weight_q;
              end
              mode_q <= req_mode;
              span_q <= len_q;
              frem_q <= '0;
            end
            CMD_ADVANCE: begin
              pos_q <= sat_add(pos_neg ? '0 : pos_q, ms_q);
            end
            default: begin
            end
          endcase
        end
        OP_TICK_POS: begin
          if (wrap && !loop_q && mode_q != MODE_OUT) begin
            active_q <= 1'b0;
          end
          pos_q <= pos_neg ? '0 : sat_add(pos_base, ms_q);
        end
        OP_FADE: begin
          if (mode_q == MODE_IN) begin
            if (span_q == '0 || lvl_sum >= (DVD_W + 1)'(FADE_ONE)) begin
              weight_q <= FADE_ONE;
              mode_q   <= MODE_NONE;
            end else begin
              weight_q <= lvl_sum[LVL_W-1:0];
            end
          end else begin
            if (span_q == '0 || div_quot >= DVD_W'(weight_q)) begin
              weight_q <= '0;
              active_q <= 1'b0;
            end else begin
              weight_q <= weight_q - div_quot[LVL_W-1:0];
            end
          end
          if (span_q != '0) begin
            frem_q <= div_rem[LEN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.is_tick   = (cmd_q == CMD_TICK);
  assign stat_o.active    = active_q;
  assign stat_o.paused    = pause_q;
  assign stat_o.wrap_loop = wrap && loop_q;
  assign stat_o.fade_run  = (mode_q != MODE_NONE);
  assign stat_o.span_zero = (span_q == '0);
  assign stat_o.div_done  = div_done;

  assign res_o.position_ms   = pos_q;
  assign res_o.fade_level    = weight_q;
  assign res_o.is_active     = active_q;
  assign res_o.fade_mode_now = mode_q;
  assign res_o.is_paused     = pause_q;

endmodule

[rtl/core/pbfc_ctrl.sv]
// ----------------------------------------------------------------------------
// pbfc_ctrl: command sequencer of the playback controller
// Accepts one command beat at a time, steps the datapath through the exec,
// wrap, position, multiply, ramp and fade operations, and hands off the result.
// ----------------------------------------------------------------------------
module pbfc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  slot_free_i,
  output logic                  res_load_o,
  input  pbfc_pkg::pbfc_stat_t  stat_i,
  output pbfc_pkg::pbfc_ctl_t   ctl_o
);
  import pbfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_MOD,
    S_MOD_WAIT,
    S_POS,
    S_MUL,
    S_RAMP,
    S_RAMP_WAIT,
    S_FADE,
    S_OUT
  } state_e;

  state_e state_q;
  dp_op_e op_q;
  logic   ready_q;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign res_load_o = (state_q == S_OUT) && slot_free_i;
  assign in_ready_o = ready_q;
  assign ctl_o.load = accept;
  assign ctl_o.op   = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      ready_q <= 1'b1;
    end else begin
      op_q <= OP_NONE;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ready_q <= 1'b0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!stat_i.is_tick) begin
            op_q    <= OP_EXEC;
            state_q <= S_EXEC;
          end else if (!stat_i.active) begin
            state_q <= S_OUT;
          end else if (!stat_i.paused) begin
            if (stat_i.wrap_loop) begin
              op_q    <= OP_MOD_START;
              state_q <= S_MOD;
            end else begin
              op_q    <= OP_TICK_POS;
              state_q <= S_POS;
            end
          end else if (!stat_i.fade_run) begin
            state_q <= S_OUT;
          end else if (stat_i.span_zero) begin
            op_q    <= OP_FADE;
            state_q <= S_FADE;
          end else begin
            op_q    <= OP_MUL;
            state_q <= S_MUL;
          end
        end
        S_EXEC: begin
          state_q <= S_OUT;
        end
        S_MOD: begin
          state_q <= S_MOD_WAIT;
        end
        S_MOD_WAIT: begin
          if (stat_i.div_done) begin
            op_q    <= OP_TICK_POS;
            state_q <= S_POS;
          end
        end
        S_POS: begin
          if (!stat_i.fade_run) begin
            state_q <= S_OUT;
          end else if (stat_i.span_zero) begin
            op_q    <= OP_FADE;
            state_q <= S_FADE;
          end else begin
            op_q    <= OP_MUL;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          op_q    <= OP_RAMP_START;
          state_q <= S_RAMP;
        end
        S_RAMP: begin
          state_q <= S_RAMP_WAIT;
        end
        S_RAMP_WAIT: begin
          if (stat_i.div_done) begin
            op_q    <= OP_FADE;
            state_q <= S_FADE;
          end
        end
        S_FADE: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (slot_free_i) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/core/playback_position_fade_control_unit.sv]
// ----------------------------------------------------------------------------
// playback_position_fade_control_unit: animation playback and fade control
// Sequencing: play, stop, pause, fade and advance are decoded, executed and
// loaded into the output register; a tick can take up to two passes of the
// bit-serial divider, one for the loop wrap and one for the fade ramp.
// Throughput: one command at a time; the next beat is taken once the result
// has moved into the output register, even while that result still waits.
// Reset: asynchronous, active low; state returns to not started, full level.
// ----------------------------------------------------------------------------
module playback_position_fade_control_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pbfc_cmd_if.sink                       cmd_i,
  pbfc_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [pbfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbfc_pkg::CFG_W-1:0]     cfg_data_i
);
  import pbfc_pkg::*;

  // The controller sequences each command; the datapath owns all playback
  // state. A tick runs in up to three phases: an optional loop wrap, which
  // takes the position modulo the duration on the divider; the position
  // update; and the fade ramp, where elapsed time times the fade distance,
  // plus the remainder kept from the last tick, is divided by the fade span.
  pbfc_ctl_t  ctl;
  pbfc_stat_t stat;
  pbfc_res_t  res_now;
  pbfc_res_t  res_q;
  logic       res_valid_q;
  logic       slot_free;
  logic       res_load;

  // The output register frees up in the same cycle its beat is taken.
  assign slot_free = !res_valid_q || res_o.ready;

  pbfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .slot_free_i (slot_free),
    .res_load_o  (res_load),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  pbfc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i.cmd),
    .elapsed_ms_i     (cmd_i.elapsed_ms),
    .fade_request_i   (cmd_i.fade_request),
    .fade_length_ms_i (cmd_i.fade_length_ms),
    .pause_flag_i     (cmd_i.pause_flag),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .res_o            (res_now)
  );

  // Result beat register: valid resets, the payload does not need to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_now;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.position_ms   = res_q.position_ms;
  assign res_o.fade_level    = res_q.fade_level;
  assign res_o.is_active     = res_q.is_active;
  assign res_o.fade_mode_now = res_q.fade_mode_now;
  assign res_o.is_paused     = res_q.is_paused;

  // Only one command is in flight: ready drops right after a beat is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while another one is in flight");

  // The divider only finishes while a command is being worked on.
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !cmd_i.ready)
    else $error("divider finished with no command in flight");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !res_load)
    else $error("pending result overwritten");

  // The fade level never rises above full weight.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.fade_level <= FADE_ONE))
    else $error("fade level above full weight");

endmodule
